[rtl/decaying_tone_mixer_top_defines.svh]
// Assertion macros for the decaying tone mixer.
// Used by decaying_tone_mixer_top.sv; needs clk_i and rst_ni in scope.
`ifndef DECAYING_TONE_MIXER_TOP_DEFINES_SVH
`define DECAYING_TONE_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while in reset
`define DTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset
`define DTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtm_pkg.sv]
// Package for the decaying tone mixer: state and code types, sine table.
// No dependencies; imported by decaying_tone_mixer_top.
`timescale 1ns / 1ps

package dtm_pkg;

  // Sine table geometry and Q2.30 constants
  localparam int SineDepth = 1024;
  localparam int SineAw    = $clog2(SineDepth);
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  // Widths of the fixed fields
  localparam int LenW   = 18;
  localparam int StepW  = 24;
  localparam int DecayW = 16;
  localparam int AmpW   = 15;
  localparam int SampW  = 16;
  localparam int EnvW   = 17;
  localparam int CfgW   = 18;

  localparam logic [AmpW-1:0] AmpReset    = 15'd12000;
  localparam logic [LenW-1:0] MinLenReset = 18'd1000;
  localparam logic [EnvW-1:0] EnvOne      = 17'd65536;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    CFG_MIX_ENABLE      = 2'd0,
    CFG_TONE_AMPLITUDE  = 2'd1,
    CFG_MIN_NOTE_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_MIX  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef logic signed [SampW-1:0] sine_rom_t [SineDepth];

  // Multiply by x twice, rescaling Q2.30 after each product
  function automatic logic [63:0] sq_scale(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] a;
    a = (t * x) >> 30;
    return (a * x) >> 30;
  endfunction

  // sin of r/SineDepth quarter turns as Q2.30, nine Taylor terms
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (r * HalfPiQ30) / 64'(SineDepth);
    term = x;
    sum  = x;
    term = sq_scale(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_scale(term, x) / 64'd20;
    sum  = sum + term;
    term = sq_scale(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_scale(term, x) / 64'd72;
    sum  = sum + term;
    term = sq_scale(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_scale(term, x) / 64'd156;
    sum  = sum + term;
    term = sq_scale(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_scale(term, x) / 64'd272;
    sum  = sum + term;
    return sum;
  endfunction

  // Build the full-turn Q1.15 table from the quarter wave
  function automatic sine_rom_t build_sine();
    sine_rom_t tab;
    logic [63:0] k4;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] mag;
    for (int k = 0; k < SineDepth; k++) begin
      k4 = 64'(4 * k);
      q  = k4 / 64'(SineDepth);
      r  = k4 % 64'(SineDepth);
      if (q[0]) begin
        r = 64'(SineDepth) - r;
      end
      s   = quarter_sine(r);
      mag = (s * 64'd32767 + (OneQ30 >> 1)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      tab[k[SineAw-1:0]] = (q >= 64'd2) ? -$signed(mag[SampW-1:0]) : $signed(mag[SampW-1:0]);
    end
    return tab;
  endfunction

  localparam sine_rom_t SineRom = build_sine();

endpackage

[rtl/decaying_tone_mixer_top.sv]
// Decaying tone mixer: a ring of 16-bit samples in one synchronous RAM.
// After reset the block clears the ring, one entry per cycle, with busy_o
// high until the sweep is done. A read beat (operation 1) returns the
// sample at the play position on sample_value_o with sample_valid_o high
// in the next cycle; the entry is cleared and the play position advances;
// the receiver cannot stall, so capture it then. A note beat (operation 0)
// mixes one ring entry per cycle through a read, three pipeline stages
// (sine ROM, amplitude multiply, envelope multiply) and a write-back:
// busy_o stays high while L entries are issued and the pipeline drains, L
// being note_length clamped to BUFFER_DEPTH - 1. An ignored note leaves
// busy_o low. Depends on dtm_pkg and decaying_tone_mixer_top_defines.svh.
`timescale 1ns / 1ps
`include "decaying_tone_mixer_top_defines.svh"

module decaying_tone_mixer_top
  import dtm_pkg::*;
#(
  parameter int BUFFER_DEPTH = 262144
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Command channel
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    operation_i,
  input  logic [StepW-1:0]        phase_step_i,
  input  logic [LenW-1:0]         note_length_i,
  input  logic [DecayW-1:0]       decay_factor_i,
  // Result channel
  output logic                    sample_valid_o,
  output logic signed [SampW-1:0] sample_value_o,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_data_i
);

  localparam int Aw   = $clog2(BUFFER_DEPTH);
  localparam int CntW = (Aw > LenW) ? Aw : LenW;
  localparam logic [Aw-1:0]   LastAddr = Aw'(BUFFER_DEPTH - 1);
  localparam logic [CntW-1:0] MaxLen   = CntW'(BUFFER_DEPTH - 1);

  // Ring memory and sine ROM
  logic signed [SampW-1:0] ring_mem [BUFFER_DEPTH];
  logic signed [SampW-1:0] rdata_q;
  logic signed [SampW-1:0] sine_q;

  // Control state
  state_e          state_q, state_d;
  logic [Aw-1:0]   clr_addr_q;
  logic [Aw-1:0]   play_pos_q;
  logic [CntW-1:0] rem_q;
  logic            rd_pend_q;
  logic            v1_q, v2_q, v3_q;
  logic            mix_en_q;
  logic [AmpW-1:0] amp_q;
  logic [LenW-1:0] min_len_q;

  // Note generator and pipeline payload
  logic [Aw-1:0]           mix_addr_q;
  logic [StepW-1:0]        phase_q, step_q;
  logic [EnvW-1:0]         env_q;
  logic [DecayW-1:0]       decay_q;
  logic [Aw-1:0]           addr_s1_q, addr_s2_q, addr_s3_q;
  logic [EnvW-1:0]         env_s1_q, env_s2_q;
  logic signed [SampW-1:0] old_s2_q, old_s3_q;
  logic signed [30:0]      p_q;
  logic signed [47:0]      pe_q;

  // Combinational signals
  logic                    accept;
  logic                    take_read;
  logic                    take_note;
  logic [CntW-1:0]         len_c;
  logic [CntW-1:0]         len_clamped;
  logic                    issue;
  logic [Aw-1:0]           rd_addr;
  logic                    mem_we;
  logic [Aw-1:0]           mem_wa;
  logic signed [SampW-1:0] mem_wd;
  logic [24+SineAw:0]      idx_prod;
  logic [SineAw-1:0]       sine_idx;
  logic [32:0]             env_prod;
  logic signed [31:0]      p_full;
  logic signed [48:0]      pe_full;
  logic signed [48:0]      total;
  logic signed [48:0]      adj;
  logic signed [17:0]      quo;
  logic signed [SampW-1:0] mix_val;

  // Decode the command beat
  assign accept    = start_i && !busy_o;
  assign take_read = accept && (operation_i == OP_READ);
  assign len_c     = CntW'(note_length_i);
  assign len_clamped = (len_c > MaxLen) ? MaxLen : len_c;
  assign take_note = accept && (operation_i == OP_MIX) && mix_en_q &&
                     (note_length_i > min_len_q);

  // Next state and busy
  always_comb begin
    state_d = state_q;
    busy_o  = 1'b1;
    issue   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (take_note) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        issue = 1'b1;
        if (rem_q == CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // the last write-back retires at this edge
        if (!v1_q && !v2_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      play_pos_q <= '0;
      rem_q      <= '0;
      rd_pend_q  <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= take_read;
      v1_q      <= issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (take_read) begin
        play_pos_q <= (play_pos_q == LastAddr) ? '0 : play_pos_q + 1'b1;
      end
      if (take_note) begin
        rem_q <= len_clamped;
      end else if (issue) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_en_q  <= 1'b0;
      amp_q     <= AmpReset;
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIX_ENABLE:      mix_en_q  <= cfg_data_i[0];
        CFG_TONE_AMPLITUDE:  amp_q     <= cfg_data_i[AmpW-1:0];
        CFG_MIN_NOTE_LENGTH: min_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Phase and envelope generator
  assign env_prod = env_q * decay_q;

  always_ff @(posedge clk_i) begin
    if (take_note) begin
      mix_addr_q <= play_pos_q;
      phase_q    <= '0;
      env_q      <= EnvOne;
      step_q     <= phase_step_i;
      decay_q    <= decay_factor_i;
    end else if (issue) begin
      mix_addr_q <= (mix_addr_q == LastAddr) ? '0 : mix_addr_q + 1'b1;
      phase_q    <= phase_q + step_q;
      env_q      <= env_prod[32:16];
    end
  end

  // Sine ROM, indexed by the phase of the issuing cycle and registered
  assign idx_prod = {{(SineAw + 1){1'b0}}, phase_q} * (SineAw + 25)'(SineDepth);
  assign sine_idx = idx_prod[24 +: SineAw];

  always_ff @(posedge clk_i) begin
    sine_q <= SineRom[sine_idx];
  end

  // Ring port select: clear sweep, write-back, or read-and-clear
  assign rd_addr = (state_q == ST_MIX) ? mix_addr_q : play_pos_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = play_pos_q;
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
    end else if (v3_q) begin
      mem_we = 1'b1;
      mem_wa = addr_s3_q;
      mem_wd = mix_val;
    end else if (take_read) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= ring_mem[rd_addr];
  end

  // Multiply pipeline: amplitude, then envelope
  assign p_full  = $signed({1'b0, amp_q}) * sine_q;
  assign pe_full = p_q * $signed({1'b0, env_s2_q});

  always_ff @(posedge clk_i) begin
    addr_s1_q <= mix_addr_q;
    env_s1_q  <= env_q;
    addr_s2_q <= addr_s1_q;
    env_s2_q  <= env_s1_q;
    old_s2_q  <= rdata_q;
    p_q       <= p_full[30:0];
    addr_s3_q <= addr_s2_q;
    old_s3_q  <= old_s2_q;
    pe_q      <= pe_full[47:0];
  end

  // Add to old sample, scale down truncating toward zero, saturate
  always_comb begin
    total = $signed({{2{old_s3_q[SampW-1]}}, old_s3_q, 31'd0}) + $signed({pe_q[47], pe_q});
    adj   = total + (total[48] ? 49'sd2147483647 : 49'sd0);
    quo   = adj[48:31];
    if (quo > 18'sd32767) begin
      mix_val = 16'sh7FFF;
    end else if (quo < -18'sd32768) begin
      mix_val = 16'sh8000;
    end else begin
      mix_val = quo[SampW-1:0];
    end
  end

  // Result beat
  assign sample_valid_o = rd_pend_q;
  assign sample_value_o = rdata_q;

  // Checks
  `DTM_ASSERT_NEXT(a_read_gives_beat, take_read, sample_valid_o, "read lost its result beat")
  `DTM_ASSERT_NOW(a_beat_from_read, sample_valid_o, $past(take_read), "result beat without read")
  `DTM_ASSERT_NOW(a_pipe_holds_busy, v1_q || v2_q || v3_q, busy_o, "command taken mid-mix")
  `DTM_ASSERT_NEXT(a_mix_keeps_play, state_q == ST_MIX, $stable(play_pos_q), "mix moved play position")

endmodule
